// ----- hdl/least_loaded_destination_select_macros.svh -----
// Assertion helpers for the destination selector.
`ifndef LEAST_LOADED_DESTINATION_SELECT_MACROS_SVH
`define LEAST_LOADED_DESTINATION_SELECT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LDS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define LDS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/lds_pkg.sv -----
`default_nettype none

package lds_pkg;

   // field widths of one candidate word
   localparam int TypeW   = 64;
   localparam int CountW  = 16;
   localparam int RecW    = 32;
   localparam int BytesW  = 64;
   localparam int IdW     = 8;

   // bit offsets inside req_tdata, lowest field first
   localparam int TrigLo  = 0;
   localparam int MaskLo  = TrigLo + TypeW;
   localparam int ThrLo   = MaskLo + TypeW;
   localparam int BldLo   = ThrLo + CountW;
   localparam int WrtLo   = BldLo + CountW;
   localparam int RecLo   = WrtLo + CountW;
   localparam int BytesLo = RecLo + RecW;
   localparam int IdLo    = BytesLo + BytesW;
   localparam int ReqDataBits = IdLo + IdW;
   localparam int ReqDataW    = ((ReqDataBits + 7) / 8) * 8;

   localparam int RspDataW = IdW;

   // candidate after filtering and open-slot calculation
   typedef struct packed {
      logic              pass;
      logic              last;
      logic [CountW-1:0] open;
      logic [RecW-1:0]   records;
      logic [BytesW-1:0] bytes;
      logic [IdW-1:0]    dest_id;
   } cand_type;

   // decision closed by a last word
   typedef struct packed {
      logic           found;
      logic [IdW-1:0] chosen_id;
   } res_type;

endpackage

`default_nettype wire

// ----- hdl/lds_prep.sv -----
`default_nettype none

module lds_prep #(
   parameter int COUNT_BITS = 16,
   parameter int ID_BITS    = 8
) (
   input  wire logic [lds_pkg::ReqDataW-1:0] data,
   input  wire logic                         last,
   output lds_pkg::cand_type                 cand
);
   import lds_pkg::*;

   localparam int CntW = (COUNT_BITS < CountW) ? COUNT_BITS : CountW;
   localparam int IdUW = (ID_BITS < IdW) ? ID_BITS : IdW;

   logic [TypeW-1:0] trig;
   logic [TypeW-1:0] mask;
   logic [CntW-1:0]  thr;
   logic [CntW-1:0]  bld;
   logic [CntW-1:0]  wrt;
   logic [CntW:0]    occ;
   logic [CntW-1:0]  diff;
   logic [CntW-1:0]  open;

   // unpack and keep only the used count and id bits
   assign trig = data[TrigLo +: TypeW];
   assign mask = data[MaskLo +: TypeW];
   assign thr  = data[ThrLo +: CntW];
   assign bld  = data[BldLo +: CntW];
   assign wrt  = data[WrtLo +: CntW];

   // open slots, saturating at zero; occupancy carries one extra bit
   assign occ  = {1'b0, bld} + {1'b0, wrt};
   assign diff = thr - occ[CntW-1:0];
   assign open = ({1'b0, thr} > occ) ? diff : '0;

   always_comb begin
      cand.pass    = |(trig & mask);
      cand.last    = last;
      cand.open    = CountW'(open);
      cand.records = data[RecLo +: RecW];
      cand.bytes   = data[BytesLo +: BytesW];
      cand.dest_id = IdW'(data[IdLo +: IdUW]);
   end

endmodule

`default_nettype wire

// ----- hdl/lds_rank.sv -----
`default_nettype none

module lds_rank #(
   parameter int COUNT_BITS = 16,
   parameter int ID_BITS    = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        cand_valid,
   input  lds_pkg::cand_type cand,
   output lds_pkg::res_type  res
);
   import lds_pkg::*;

   localparam int CntW = (COUNT_BITS < CountW) ? COUNT_BITS : CountW;
   localparam int IdUW = (ID_BITS < IdW) ? ID_BITS : IdW;

   logic              have_best_ff, have_best_in;
   logic [CntW-1:0]   best_open_ff, best_open_in;
   logic [RecW-1:0]   best_records_ff, best_records_in;
   logic [BytesW-1:0] best_bytes_ff, best_bytes_in;
   logic [IdUW-1:0]   best_id_ff, best_id_in;

   logic [CntW-1:0]   c_open;
   logic [IdUW-1:0]   c_id;
   logic              better;
   logic              win;

   assign c_open = cand.open[CntW-1:0];
   assign c_id   = cand.dest_id[IdUW-1:0];

   // ranking: most open slots, fewest records, fewest bytes, lowest id
   always_comb begin
      priority if (!have_best_ff) begin
         better = 1'b1;
      end else if (c_open != best_open_ff) begin
         better = c_open > best_open_ff;
      end else if (cand.records != best_records_ff) begin
         better = cand.records < best_records_ff;
      end else if (cand.bytes != best_bytes_ff) begin
         better = cand.bytes < best_bytes_ff;
      end else begin
         better = c_id < best_id_ff;
      end
   end

   assign win = cand.pass && better;

   // result of a closing word, taken from the updated best
   always_comb begin
      res.found     = have_best_ff || cand.pass;
      res.chosen_id = '0;
      if (win) begin
         res.chosen_id = IdW'(c_id);
      end else if (have_best_ff) begin
         res.chosen_id = IdW'(best_id_ff);
      end
   end

   // running best; a closing word empties it
   always_comb begin
      have_best_in    = have_best_ff;
      best_open_in    = best_open_ff;
      best_records_in = best_records_ff;
      best_bytes_in   = best_bytes_ff;
      best_id_in      = best_id_ff;
      if (cand_valid) begin
         if (win) begin
            have_best_in    = 1'b1;
            best_open_in    = c_open;
            best_records_in = cand.records;
            best_bytes_in   = cand.bytes;
            best_id_in      = c_id;
         end
         if (cand.last) begin
            have_best_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_best_ff <= 1'b0;
      end else begin
         have_best_ff <= have_best_in;
      end
   end

   // payload of the best needs no reset: have_best gates it
   always_ff @(posedge clock) begin
      best_open_ff    <= best_open_in;
      best_records_ff <= best_records_in;
      best_bytes_ff   <= best_bytes_in;
      best_id_ff      <= best_id_in;
   end

endmodule

`default_nettype wire

// ----- hdl/least_loaded_destination_select.sv -----
// Channel  Direction  Payload
// req      in         tdata: candidate status word, tlast: last candidate
// rsp      out        tdata: chosen_id, tuser: found
//
// One candidate word per cycle while no last word waits on the output register.
// A word is held in the input register, where it is ranked against the running
// best held in lds_rank. A last word puts its result in the output register as it leaves the input register.
// The output register is the only stall point: a last word waits in the input
// register while an earlier result is still untaken; other words keep moving.
// Synchronous reset clears the valid flags and the running best.
`default_nettype none

module least_loaded_destination_select #(
   parameter int ID_BITS    = 8,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output      logic                         req_tready,
   // trig_set, type_mask, slot_limit, building_count, writing_count,
   // records_done, bytes_done, dest_id
   input  wire logic [lds_pkg::ReqDataW-1:0] req_tdata,
   input  wire logic                         req_tlast,
   output      logic                         rsp_tvalid,
   input  wire logic                         rsp_tready,
   // chosen_id
   output      logic [lds_pkg::RspDataW-1:0] rsp_tdata,
   // found
   output      logic                         rsp_tuser
);
   import lds_pkg::*;

   cand_type cand_in, in_ff;
   logic     in_valid_ff, in_valid_in;
   logic     adv;
   logic     rsp_free;
   res_type  res;
   res_type  rsp_ff, rsp_in;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     closing;
   logic     rsp_held;
   logic     rsp_empty;

   // filter and open slots ahead of the input register
   lds_prep #(
      .COUNT_BITS(COUNT_BITS),
      .ID_BITS   (ID_BITS)
   ) u_prep (
      .data(req_tdata),
      .last(req_tlast),
      .cand(cand_in)
   );

   // handshake: a last word needs room in the output register
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign adv        = in_valid_ff && (!in_ff.last || rsp_free);
   assign req_tready = !in_valid_ff || adv;

   assign in_valid_in = req_tvalid || (in_valid_ff && !adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_ff <= cand_in;
      end
   end

   lds_rank #(
      .COUNT_BITS(COUNT_BITS),
      .ID_BITS   (ID_BITS)
   ) u_rank (
      .clock     (clock),
      .reset     (reset),
      .cand_valid(adv),
      .cand      (in_ff),
      .res       (res)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      if (adv && in_ff.last) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.chosen_id;
   assign rsp_tuser  = rsp_ff.found;

   // terms for the checks below
   assign closing   = adv && in_ff.last;
   assign rsp_held  = rsp_valid_ff && !rsp_tready;
   assign rsp_empty = rsp_tvalid && !rsp_tuser;

`include "least_loaded_destination_select_macros.svh"

   // a closing word always lands in the output register
   `LDS_ASSERT_NEXT(a_last_gives_word, clock, reset, closing, rsp_tvalid, "last word lost")

   // a new result only ever follows a closing word
   `LDS_ASSERT_NEXT(a_no_stray, clock, reset, !closing && !rsp_held, !rsp_tvalid, "stray result")

   // not-found results carry a zero id
   `LDS_ASSERT_NOW(a_empty_id, clock, reset, rsp_empty, rsp_tdata == '0, "id on not-found")

endmodule

`default_nettype wire

// ----- tb/sv/least_loaded_destination_select_checker.sv -----
`default_nettype none

module least_loaded_destination_select_checker (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   input  wire logic                         req_tready,
   // trig_set, type_mask, slot_limit, building_count, writing_count,
   // records_done, bytes_done, dest_id
   input  wire logic [lds_pkg::ReqDataW-1:0] req_tdata,
   input  wire logic                         req_tlast,
   input  wire logic                         rsp_tvalid,
   input  wire logic                         rsp_tready,
   // chosen_id
   input  wire logic [lds_pkg::RspDataW-1:0] rsp_tdata,
   // found
   input  wire logic                         rsp_tuser,
   output int                                fail_count,
   output int                                outstanding
);
   import lds_pkg::*;

   // running best of the open decision
   logic              lead_valid;
   logic [CountW-1:0] lead_open;
   logic [RecW-1:0]   lead_records;
   logic [BytesW-1:0] lead_bytes;
   logic [IdW-1:0]    lead_id;

   // choices still owed by the block, oldest first
   res_type choice_q[$];

   // fields of the word being accepted
   logic [TypeW-1:0]  w_trig;
   logic [TypeW-1:0]  w_mask;
   logic [CountW-1:0] w_thr;
   logic [CountW:0]   w_occ;
   logic [CountW-1:0] w_open;
   logic [RecW-1:0]   w_recs;
   logic [BytesW-1:0] w_bytes;
   logic [IdW-1:0]    w_id;
   logic              takes_lead;
   res_type           owed;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         lead_valid   = 1'b0;
         lead_open    = '0;
         lead_records = '0;
         lead_bytes   = '0;
         lead_id      = '0;
         choice_q.delete();
         fail_count   = 0;
      end else begin
         // result side: compare with the oldest owed choice
         if (rsp_tvalid && rsp_tready) begin
            if (choice_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result found=%b id=%0d",
                                         rsp_tuser, rsp_tdata));
            end else begin
               owed = choice_q.pop_front();
               if (rsp_tuser !== owed.found)
                  report_mismatch($sformatf("found %b, wanted %b", rsp_tuser, owed.found));
               if (rsp_tdata !== owed.chosen_id)
                  report_mismatch($sformatf("chosen_id %0d, wanted %0d",
                                            rsp_tdata, owed.chosen_id));
            end
         end

         // candidate side: filter, rank, close the decision on tlast
         if (req_tvalid && req_tready) begin
            w_trig  = req_tdata[TrigLo  +: TypeW];
            w_mask  = req_tdata[MaskLo  +: TypeW];
            w_thr   = req_tdata[ThrLo   +: CountW];
            w_occ   = {1'b0, req_tdata[BldLo +: CountW]} + {1'b0, req_tdata[WrtLo +: CountW]};
            w_recs  = req_tdata[RecLo   +: RecW];
            w_bytes = req_tdata[BytesLo +: BytesW];
            w_id    = req_tdata[IdLo    +: IdW];
            if ((w_trig & w_mask) != '0) begin
               // open slots saturate at zero; the sum carries one extra bit
               w_open = ({1'b0, w_thr} > w_occ) ? w_thr - w_occ[CountW-1:0] : '0;
               if (!lead_valid)
                  takes_lead = 1'b1;
               else if (w_open != lead_open)
                  takes_lead = w_open > lead_open;
               else if (w_recs != lead_records)
                  takes_lead = w_recs < lead_records;
               else if (w_bytes != lead_bytes)
                  takes_lead = w_bytes < lead_bytes;
               else
                  takes_lead = w_id < lead_id;
               if (takes_lead) begin
                  lead_valid   = 1'b1;
                  lead_open    = w_open;
                  lead_records = w_recs;
                  lead_bytes   = w_bytes;
                  lead_id      = w_id;
               end
            end
            if (req_tlast) begin
               owed.found     = lead_valid;
               owed.chosen_id = lead_valid ? lead_id : '0;
               choice_q.insert(choice_q.size(), owed);
               lead_valid   = 1'b0;
               lead_open    = '0;
               lead_records = '0;
               lead_bytes   = '0;
               lead_id      = '0;
            end
         end
      end
      outstanding <= choice_q.size();
   end

endmodule

`default_nettype wire

// ----- tb/sv/least_loaded_destination_select_tb.sv -----
`default_nettype none

module least_loaded_destination_select_tb;
   import lds_pkg::*;

   localparam int WordTarget = 1650;
   localparam int LongHold   = 300;
   localparam int DrainLimit = 2000;

   typedef struct {
      logic [TypeW-1:0]  trig;
      logic [TypeW-1:0]  mask;
      logic [CountW-1:0] thr;
      logic [CountW-1:0] bld;
      logic [CountW-1:0] wrt;
      logic [RecW-1:0]   recs;
      logic [BytesW-1:0] bytes;
      logic [IdW-1:0]    id;
      logic              last;
   } status_word_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   // trig_set, type_mask, slot_limit, building_count, writing_count,
   // records_done, bytes_done, dest_id
   logic [ReqDataW-1:0] req_tdata;
   logic                req_tlast;
   logic                rsp_tvalid;
   logic                rsp_tready;
   // chosen_id
   logic [RspDataW-1:0] rsp_tdata;
   // found
   logic                rsp_tuser;

   int fail_count;
   int outstanding;

   // pacing shared between sender and receiver
   bit req_steady;
   bit rsp_steady;
   int hold_requests;
   int words_sent;

   least_loaded_destination_select u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   least_loaded_destination_select_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit, far beyond the slowest correct run
   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end

   function automatic logic [63:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   function automatic status_word_type make_word(
      input logic [TypeW-1:0]  trig,
      input logic [TypeW-1:0]  mask,
      input logic [CountW-1:0] thr,
      input logic [CountW-1:0] bld,
      input logic [CountW-1:0] wrt,
      input logic [RecW-1:0]   recs,
      input logic [BytesW-1:0] bytes,
      input logic [IdW-1:0]    id,
      input logic              last
   );
      status_word_type w;
      w.trig  = trig;
      w.mask  = mask;
      w.thr   = thr;
      w.bld   = bld;
      w.wrt   = wrt;
      w.recs  = recs;
      w.bytes = bytes;
      w.id    = id;
      w.last  = last;
      return w;
   endfunction

   // random candidate: small pools most of the time so that ties occur
   function automatic status_word_type random_candidate(input logic [TypeW-1:0] trig,
                                                        input logic last);
      status_word_type w;
      w.trig = trig;
      case ($urandom_range(0, 7))
         0:       w.mask = '1;
         1:       w.mask = '0;
         2, 3:    w.mask = rnd64() & ~trig;
         default: w.mask = rnd64() | (trig & -trig);
      endcase
      w.thr   = ($urandom_range(0, 3) == 0) ? CountW'($urandom) : CountW'($urandom_range(0, 8));
      w.bld   = ($urandom_range(0, 3) == 0) ? CountW'($urandom) : CountW'($urandom_range(0, 4));
      w.wrt   = ($urandom_range(0, 3) == 0) ? CountW'($urandom) : CountW'($urandom_range(0, 4));
      w.recs  = ($urandom_range(0, 3) == 0) ? RecW'($urandom) : RecW'($urandom_range(0, 3));
      w.bytes = ($urandom_range(0, 3) == 0) ? rnd64() : BytesW'($urandom_range(0, 3));
      w.id    = ($urandom_range(0, 3) == 0) ? IdW'($urandom) : IdW'($urandom_range(0, 7));
      w.last  = last;
      return w;
   endfunction

   // offer one word after a drawn gap and wait for it to be taken
   task automatic send_word(input status_word_type w);
      logic [ReqDataW-1:0] d;
      int gap;
      d = '0;
      d[TrigLo  +: TypeW]  = w.trig;
      d[MaskLo  +: TypeW]  = w.mask;
      d[ThrLo   +: CountW] = w.thr;
      d[BldLo   +: CountW] = w.bld;
      d[WrtLo   +: CountW] = w.wrt;
      d[RecLo   +: RecW]   = w.recs;
      d[BytesLo +: BytesW] = w.bytes;
      d[IdLo    +: IdW]    = w.id;
      gap = req_steady ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tlast  <= w.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
   endtask

   // one decision: a run of candidates sharing a trigger type
   task automatic send_run(input int len);
      logic [TypeW-1:0] trig;
      case ($urandom_range(0, 7))
         0:          trig = '0;
         1, 2, 3, 4: trig = 64'd1 << $urandom_range(0, 63);
         default:    trig = rnd64();
      endcase
      for (int i = 0; i < len; i++)
         send_word(random_candidate(trig, i == len - 1));
   endtask

   // sender stops and waits for every owed choice to come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // receiver: random stall before each word, long hold-off on request
   initial begin : receiver
      int stall;
      int holds_done;
      rsp_tready = 1'b0;
      holds_done = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (holds_done != hold_requests) begin
            holds_done++;
            rsp_tready <= 1'b0;
            repeat (LongHold) @(posedge clock);
         end
         stall = rsp_steady ? 0 : $urandom_range(0, 10);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // stimulus and verdict
   initial begin : stimulus
      logic [TypeW-1:0] top_bit;
      int phase;
      int phase_words;
      int drain_wait;
      int run_len;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tlast     = 1'b0;
      req_steady    = 1'b0;
      rsp_steady    = 1'b0;
      hold_requests = 0;
      words_sent    = 0;
      top_bit       = 64'd1 << 63;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ranking keys one after another, skipped candidates, tied words
      send_word(make_word(top_bit, top_bit, 5, 0, 0, 100, 1000, 7, 0));
      send_word(make_word(top_bit, ~top_bit, '1, 0, 0, 0, 0, 1, 0));
      send_word(make_word(top_bit, '1, 7, 1, 1, 50, 5000, 9, 0));
      send_word(make_word(top_bit, top_bit, 5, 0, 0, 50, 4000, 200, 0));
      send_word(make_word(top_bit, top_bit, 5, 0, 0, 50, 4000, 3, 0));
      send_word(make_word(top_bit, top_bit, 6, 1, 0, 50, 4000, 3, 0));
      // occupancy past the threshold, where a 16-bit sum would wrap
      send_word(make_word(top_bit, top_bit, 10, '1, 1, 0, 0, 4, 0));
      send_word(make_word(top_bit, '0, '1, 0, 0, 0, 0, 99, 1));
      // field extremes in single-word decisions
      send_word(make_word('1, '1, '1, 0, 0, '1, '1, '1, 1));
      send_word(make_word('0, '1, '1, 0, 0, 0, 0, 5, 1));
      // a fresh decision after the clear, both candidates with no room
      send_word(make_word(1, 1, 0, 0, 0, 0, 0, 10, 0));
      send_word(make_word(1, 3, '1, '1, '1, 0, 0, 0, 1));
      // more room beats fewer records
      send_word(make_word(2, 2, 100, 50, 49, 0, 0, 0, 0));
      send_word(make_word(2, 6, '1, 0, 0, '1, '1, '1, 1));
      // nothing passes over several words
      send_word(make_word(64'h00FF, 64'hFF00, 9, 0, 0, 0, 0, 1, 0));
      send_word(make_word(64'h00FF, 64'hFF00, 9, 0, 0, 0, 0, 2, 0));
      send_word(make_word(64'h00FF, 64'hFF00, 9, 0, 0, 0, 0, 3, 1));
      wait_drained();

      // random decisions, in phases of varying pace
      phase = 0;
      while (words_sent < WordTarget) begin
         phase++;
         req_steady  = (phase % 4 == 1) || (phase % 6 == 3);
         rsp_steady  = (phase % 4 == 2);
         phase_words = 0;
         if (phase % 6 == 3) begin
            // receiver holds off while single-word decisions pile up
            hold_requests++;
            while (phase_words < 40) begin
               send_run(1);
               phase_words++;
            end
         end else begin
            while (phase_words < 120) begin
               if ($urandom_range(0, 9) == 0) begin
                  run_len = $urandom_range(9, 40);
               end else begin
                  run_len = $urandom_range(1, 8);
               end
               send_run(run_len);
               phase_words += run_len;
               if (words_sent >= WordTarget) break;
            end
         end
         if (phase % 5 == 0) wait_drained();
      end

      // drain, then a short tail for the output register
      req_tvalid <= 1'b0;
      drain_wait = 0;
      repeat (2) @(posedge clock);
      while (outstanding != 0 && drain_wait < DrainLimit) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (20) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
